// File: rtl/tcpq_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the three-class priority queue
// no dependencies

package tcpq_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned CLS_W  = 2;
  localparam int unsigned OCC_W  = 6;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // queue classes
  localparam logic [CLS_W-1:0] CLS_LOW = 2'd2;

  // requested operation, carried on the slave tuser
  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

  // result status, carried on the master tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_DEQUEUED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ_SCAN,
    ST_ENQ_PUT,
    ST_DEQ_OUT
  } state_e;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
  } entry_t;

endpackage

// File: rtl/three_class_priority_queue.sv
`timescale 1ns / 1ps
// three-class stable priority queue: sequencer, ring pointers and result register
// depends on tcpq_pkg and tcpq_store
//
// usage
//   the slave stream carries one command per transfer: tuser selects enqueue
//   or dequeue, tdata holds the entry id and class. the master stream returns
//   one result per command: tuser is the status, tdata holds the served id,
//   served class and the occupancy after the command.
//   entries are held in a ring in one memory, ordered by class and, within a
//   class, by arrival. dequeue takes the head and just moves the head pointer.
//   enqueue walks back from the tail, one stored entry per cycle through the
//   one class comparator, moving each less urgent entry back a slot.
// result timing
//   full enqueue or empty dequeue: result in the cycle after the transfer
//   dequeue: the head is read from the store, then registered as the result
//   enqueue: the scan state moves each held entry less urgent than the new
//   one (at most DEPTH-1) back a slot, bound by the single read and write
//   port of the store, then the result is registered. one command is in work at a time.
// reset and stalls
//   reset empties the queue; the store itself is not cleared. a result waits
//   in the output register while the receiver stalls, and no new command is
//   taken until it has gone or goes in that cycle.

module three_class_priority_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] entry_id, [17:16] entry_class, [23:18] zero
  input  logic [tcpq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] served_id, [17:16] served_class, [23:18] occupancy
  output logic [tcpq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [tcpq_pkg::STAT_W-1:0]         m_axis_tuser
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);

  tcpq_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] left_q, left_d;
  tcpq_pkg::entry_t new_q, new_d;

  logic out_valid_q, out_valid_d;
  tcpq_pkg::status_e out_stat_q, out_stat_d;
  tcpq_pkg::entry_t out_entry_q, out_entry_d;
  logic [tcpq_pkg::OCC_W-1:0] out_occ_q, out_occ_d;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  tcpq_pkg::entry_t mem_wdata, mem_rdata;

  logic accept, is_full, is_empty, move_back;
  logic [AW:0] tail_sum;
  logic [AW-1:0] tail_slot, ptr_inc, ptr_dec, head_inc;
  tcpq_pkg::entry_t in_entry;

  assign s_axis_tready = (state_q == tcpq_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);

  // class three is taken as low
  always_comb begin
    in_entry.id  = s_axis_tdata[tcpq_pkg::ID_W-1:0];
    in_entry.cls = s_axis_tdata[tcpq_pkg::ID_W +: tcpq_pkg::CLS_W];
    if (in_entry.cls > tcpq_pkg::CLS_LOW) begin
      in_entry.cls = tcpq_pkg::CLS_LOW;
    end
  end

  // ring arithmetic: tail = head + count - 1, wrapped once
  always_comb begin
    tail_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q) - (AW + 1)'(1);
    if (tail_sum >= DEPTH_W) begin
      tail_sum = tail_sum - DEPTH_W;
    end
    tail_slot = tail_sum[AW-1:0];
  end

  assign ptr_inc  = (ptr_q == LAST_SLOT) ? '0 : ptr_q + AW'(1);
  assign ptr_dec  = (ptr_q == '0) ? LAST_SLOT : ptr_q - AW'(1);
  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);

  // the shared comparator: is the stored entry less urgent than the new one
  assign move_back = (mem_rdata.cls > new_q.cls);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (tcpq_pkg::action_e'(s_axis_tuser) == tcpq_pkg::ACT_ENQUEUE) begin
            if (!is_full) begin
              state_d = is_empty ? tcpq_pkg::ST_ENQ_PUT : tcpq_pkg::ST_ENQ_SCAN;
            end
          end else if (!is_empty) begin
            state_d = tcpq_pkg::ST_DEQ_OUT;
          end
        end
      end
      tcpq_pkg::ST_ENQ_SCAN: begin
        if (!move_back) begin
          state_d = tcpq_pkg::ST_IDLE;
        end else if (left_q == '0) begin
          state_d = tcpq_pkg::ST_ENQ_PUT;
        end
      end
      tcpq_pkg::ST_ENQ_PUT: state_d = tcpq_pkg::ST_IDLE;
      tcpq_pkg::ST_DEQ_OUT: state_d = tcpq_pkg::ST_IDLE;
      default: state_d = tcpq_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    new_d       = new_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_inc;
    mem_wdata   = new_q;
    mem_raddr   = ptr_dec;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_entry_d = out_entry_q;
    out_occ_d   = out_occ_q;

    unique case (state_q)
      tcpq_pkg::ST_IDLE: begin
        mem_raddr = head_q;
        if (accept) begin
          new_d = in_entry;
          if (tcpq_pkg::action_e'(s_axis_tuser) == tcpq_pkg::ACT_ENQUEUE) begin
            mem_raddr = tail_slot;
            ptr_d     = tail_slot;
            left_d    = AW'(count_q - CW'(1));
            if (is_full) begin
              out_valid_d = 1'b1;
              out_stat_d  = tcpq_pkg::STAT_FULL;
              out_entry_d = '0;
              out_occ_d   = tcpq_pkg::OCC_W'(count_q);
            end
          end else if (is_empty) begin
            out_valid_d = 1'b1;
            out_stat_d  = tcpq_pkg::STAT_EMPTY;
            out_entry_d = '0;
            out_occ_d   = tcpq_pkg::OCC_W'(count_q);
          end
        end
      end
      tcpq_pkg::ST_ENQ_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc;
        if (move_back) begin
          mem_wdata = mem_rdata;
          mem_raddr = ptr_dec;
          ptr_d     = ptr_dec;
          left_d    = left_q - AW'(1);
        end else begin
          mem_wdata   = new_q;
          count_d     = count_q + CW'(1);
          out_valid_d = 1'b1;
          out_stat_d  = tcpq_pkg::STAT_ENQUEUED;
          out_entry_d = '0;
          out_occ_d   = tcpq_pkg::OCC_W'(count_d);
        end
      end
      tcpq_pkg::ST_ENQ_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = head_q;
        mem_wdata   = new_q;
        count_d     = count_q + CW'(1);
        out_valid_d = 1'b1;
        out_stat_d  = tcpq_pkg::STAT_ENQUEUED;
        out_entry_d = '0;
        out_occ_d   = tcpq_pkg::OCC_W'(count_d);
      end
      tcpq_pkg::ST_DEQ_OUT: begin
        head_d      = head_inc;
        count_d     = count_q - CW'(1);
        out_valid_d = 1'b1;
        out_stat_d  = tcpq_pkg::STAT_DEQUEUED;
        out_entry_d = mem_rdata;
        out_occ_d   = tcpq_pkg::OCC_W'(count_d);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcpq_pkg::ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    left_q      <= left_d;
    new_q       <= new_d;
    out_stat_q  <= out_stat_d;
    out_entry_q <= out_entry_d;
    out_occ_q   <= out_occ_d;
  end

  tcpq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {out_occ_q, out_entry_q.cls, out_entry_q.id};

endmodule

// File: rtl/tcpq_store.sv
`timescale 1ns / 1ps
// entry storage for the priority queue: one write port, one registered read port
// depends on tcpq_pkg

module tcpq_store #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tcpq_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output tcpq_pkg::entry_t rdata_o
);

  tcpq_pkg::entry_t mem_q [DEPTH];
  tcpq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcpq_checker.sv
`timescale 1ns / 1ps
// port-level checks for the three-class priority queue, bound to the top level
// depends on tcpq_pkg

module tcpq_checker #(
  parameter int unsigned DEPTH = 32
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tcpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [tcpq_pkg::STAT_W-1:0]     m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a command is only taken when the result slot is free or emptying
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("command taken over a waiting result");

  // only a dequeue reports a served entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != tcpq_pkg::STAT_DEQUEUED) |->
      m_axis_tdata[17:0] == 18'd0)
    else $error("served entry on a non-dequeue result");

  // no served class beyond low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:16] <= tcpq_pkg::CLS_LOW)
    else $error("served class out of range");

  // occupancy never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 63) || (32'(m_axis_tdata[23:18]) <= DEPTH))
    else $error("occupancy above depth");

endmodule

bind three_class_priority_queue tcpq_checker #(
  .DEPTH(DEPTH)
) u_tcpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: sim/three_class_priority_queue_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for three_class_priority_queue: directed and random commands
// depends on tcpq_pkg and the queue rtl; keeps its own sorted-queue predictor

module three_class_priority_queue_tb;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned RANDOM_ITEMS = 810;
  localparam int unsigned HOLD_AT = 700;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam int unsigned ID_W       = tcpq_pkg::ID_W;
  localparam int unsigned CLS_W      = tcpq_pkg::CLS_W;
  localparam int unsigned OCC_W      = tcpq_pkg::OCC_W;
  localparam int unsigned STAT_W     = tcpq_pkg::STAT_W;
  localparam int unsigned IN_DATA_W  = tcpq_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = tcpq_pkg::OUT_DATA_W;

  typedef struct {
    tcpq_pkg::action_e act;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
  } cmd_t;

  typedef struct {
    tcpq_pkg::status_e status;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  three_class_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  cmd_t     cmd_q[$];
  outcome_t outcome_q[$];
  cmd_t     cur_cmd;
  int       total_cmds = 0;
  int       accepted_cnt = 0;
  int       err_cnt = 0;
  int       gen_occ = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  // predictor state: slot 0 is the head
  logic [ID_W-1:0]  pq_ids[DEPTH];
  logic [CLS_W-1:0] pq_cls[DEPTH];
  int               pq_count = 0;

  function automatic outcome_t predict_outcome(input cmd_t c);
    outcome_t         r;
    logic [CLS_W-1:0] cls;
    int               pos;
    r.id  = '0;
    r.cls = '0;
    cls = (c.cls > tcpq_pkg::CLS_LOW) ? tcpq_pkg::CLS_LOW : c.cls;
    if (c.act == tcpq_pkg::ACT_ENQUEUE) begin
      if (pq_count >= DEPTH) begin
        r.status = tcpq_pkg::STAT_FULL;
      end else begin
        pos = pq_count;
        for (int i = pq_count - 1; i >= 0; i--) begin
          if (pq_cls[i] > cls) pos = i;
        end
        for (int i = pq_count; i > pos; i--) begin
          pq_ids[i] = pq_ids[i-1];
          pq_cls[i] = pq_cls[i-1];
        end
        pq_ids[pos] = c.id;
        pq_cls[pos] = cls;
        pq_count++;
        r.status = tcpq_pkg::STAT_ENQUEUED;
      end
    end else begin
      if (pq_count == 0) begin
        r.status = tcpq_pkg::STAT_EMPTY;
      end else begin
        r.id  = pq_ids[0];
        r.cls = pq_cls[0];
        for (int i = 0; i + 1 < pq_count; i++) begin
          pq_ids[i] = pq_ids[i+1];
          pq_cls[i] = pq_cls[i+1];
        end
        pq_count--;
        r.status = tcpq_pkg::STAT_DEQUEUED;
      end
    end
    r.occ = pq_count[OCC_W-1:0];
    return r;
  endfunction

  // idle percentage per side: sender 11/47/0, receiver 47/11/0 over the run
  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (accepted_cnt < total_cmds / 3) ? 0 :
            (accepted_cnt < 2 * total_cmds / 3) ? 1 : 2;
    if (phase == 2) return 0;
    return ((phase == 0) == sender) ? 11 : 47;
  endfunction

  task automatic add_cmd(input tcpq_pkg::action_e act, input logic [ID_W-1:0] id,
                         input logic [CLS_W-1:0] cls);
    cmd_t c;
    c.act = act;
    c.id  = id;
    c.cls = cls;
    cmd_q.push_back(c);
    if (act == tcpq_pkg::ACT_ENQUEUE && gen_occ < DEPTH) gen_occ++;
    else if (act == tcpq_pkg::ACT_DEQUEUE && gen_occ > 0) gen_occ--;
  endtask

  task automatic add_random_enq();
    add_cmd(tcpq_pkg::ACT_ENQUEUE, ID_W'($urandom_range(0, 65535)),
            CLS_W'($urandom_range(0, 3)));
  endtask

  task automatic add_random_deq();
    add_cmd(tcpq_pkg::ACT_DEQUEUE, ID_W'($urandom_range(0, 65535)),
            CLS_W'($urandom_range(0, 3)));
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= tcpq_pkg::ACT_ENQUEUE;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(predict_outcome(cur_cmd));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_DATA_W - ID_W - CLS_W){1'b0}}, cur_cmd.cls, cur_cmd.id};
          s_axis_tuser  <= cur_cmd.act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the queue backs up into the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_r;
    outcome_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = tcpq_pkg::status_e'(m_axis_tuser);
        got.id     = m_axis_tdata[ID_W-1:0];
        got.cls    = m_axis_tdata[ID_W+CLS_W-1:ID_W];
        got.occ    = m_axis_tdata[ID_W+CLS_W+OCC_W-1:ID_W+CLS_W];
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result status=%0d id=%h class=%0d occ=%0d",
                     $realtime, got.status, got.id, got.cls, got.occ);
        end else begin
          exp_r = outcome_q.pop_front();
          if (got.status !== exp_r.status || got.id !== exp_r.id ||
              got.cls !== exp_r.cls || got.occ !== exp_r.occ) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: mismatch exp status=%0d id=%h class=%0d occ=%0d,",
                        " got status=%0d id=%h class=%0d occ=%0d"},
                       $realtime, exp_r.status, exp_r.id, exp_r.cls, exp_r.occ,
                       got.status, got.id, got.cls, got.occ);
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int target;
    int n;
    // empty queue first, then class order, ties, class three and extreme ids
    add_cmd(tcpq_pkg::ACT_DEQUEUE, 16'hffff, 2'd3);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'hffff, 2'd2);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'h0000, 2'd0);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'haaaa, 2'd1);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'h5555, 2'd3);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'h1234, 2'd0);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'h0f0f, 2'd1);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'hf0f0, 2'd2);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'h0001, 2'd3);
    for (int i = 0; i < 10; i++) add_cmd(tcpq_pkg::ACT_DEQUEUE, 16'h0000, 2'd0);
    add_cmd(tcpq_pkg::ACT_ENQUEUE, 16'h8000, 2'd1);
    add_cmd(tcpq_pkg::ACT_DEQUEUE, 16'h0000, 2'd0);

    // random bursts: fill towards full, drain towards empty, or mixed
    while (cmd_q.size() < RANDOM_ITEMS + 20) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        target = $urandom_range(0, 1) ? DEPTH : $urandom_range(gen_occ, DEPTH);
        while (gen_occ < target) begin
          if ($urandom_range(0, 9) == 0) add_random_deq();
          else add_random_enq();
        end
        if (target == DEPTH) begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) add_random_enq();
        end
      end else if (kind < 8) begin
        target = $urandom_range(0, 1) ? 0 : $urandom_range(0, gen_occ);
        while (gen_occ > target) begin
          if ($urandom_range(0, 9) == 0) add_random_enq();
          else add_random_deq();
        end
        if (target == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) add_random_deq();
        end
      end else begin
        n = $urandom_range(10, 30);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) != 0) add_random_enq();
          else add_random_deq();
        end
      end
    end
    total_cmds = cmd_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_cmds) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0 && outcome_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
rtl/tcpq_pkg.sv
rtl/tcpq_store.sv
rtl/three_class_priority_queue.sv
rtl/tcpq_checker.sv
sim/three_class_priority_queue_tb.sv
